>>> hw/rtl/u8dec_pkg.sv
// ----------------------------------------------------------------------------
// u8dec_pkg
// shared types and constants of the utf-8 byte stream decoder
// ----------------------------------------------------------------------------
package u8dec_pkg;

  localparam int unsigned QDepth = 4;
  localparam int unsigned QIdxW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  localparam int unsigned CpW   = 21;
  localparam int unsigned LineW = 32;

  localparam logic [7:0]     ByteNewline = 8'h0a;
  localparam logic [CpW-1:0] CpNewline   = 21'h00000a;
  localparam logic [CpW-1:0] CpOpenEnd   = 21'h0000ff;
  localparam logic [CpW-1:0] CpCleanEnd  = 21'h000000;

  // classified request as it travels from front to back
  typedef struct packed {
    logic       is_end;
    logic       is_ascii;
    logic       is_cont;
    logic       is_newline;
    logic       bad_lead;
    logic [1:0] lead_rem;
    logic [6:0] lead_val;
    logic [7:0] data;
  } item_t;

endpackage

>>> hw/rtl/u8dec_front.sv
// ----------------------------------------------------------------------------
// u8dec_front
// accepts raw bytes and classifies them into lead, continuation, ascii or invalid
// ----------------------------------------------------------------------------
module u8dec_front (
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [7:0]        data_byte_i,
  input  logic              end_of_input_i,
  input  logic              q_full_i,
  output logic              push_o,
  output u8dec_pkg::item_t  item_o
);
  import u8dec_pkg::*;

  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i & ~q_full_i;

  always_comb begin
    item_o            = '0;
    item_o.data       = data_byte_i;
    item_o.is_end     = end_of_input_i;
    item_o.is_newline = (data_byte_i == ByteNewline);
    unique casez (data_byte_i)
      8'b0???????: begin
        item_o.is_ascii = 1'b1;
      end
      8'b10??????: begin
        item_o.is_cont  = 1'b1;
        item_o.bad_lead = 1'b1;
      end
      8'b110?????: begin
        item_o.lead_rem = 2'd1;
        item_o.lead_val = {2'b00, data_byte_i[4:0]};
      end
      8'b1110????: begin
        item_o.lead_rem = 2'd2;
        item_o.lead_val = {3'b000, data_byte_i[3:0]};
      end
      8'b11110???: begin
        item_o.lead_rem = 2'd3;
        item_o.lead_val = {4'b0000, data_byte_i[2:0]};
      end
      default: begin
        item_o.bad_lead = 1'b1;
      end
    endcase
  end

endmodule

>>> hw/rtl/u8dec_queue.sv
// ----------------------------------------------------------------------------
// u8dec_queue
// small request queue between the classifier and the decode engine
// ----------------------------------------------------------------------------
module u8dec_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  u8dec_pkg::item_t  item_i,
  output logic              full_o,
  output logic              valid_o,
  output u8dec_pkg::item_t  item_o,
  input  logic              pop_i
);
  import u8dec_pkg::*;

  item_t             mem_q [QDepth];
  logic [QIdxW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [QIdxW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0]  count_q, count_d;
  logic              do_pop;

  assign full_o  = (count_q == QCntW'(QDepth));
  assign valid_o = (count_q != '0);
  assign item_o  = mem_q[rd_ptr_q];
  assign do_pop  = pop_i & valid_o;

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && do_pop) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i)
    else $error("push into full queue");

endmodule

>>> hw/rtl/u8dec_back.sv
// ----------------------------------------------------------------------------
// u8dec_back
// decode engine: sequence state, line counter, error flag and output register
// ----------------------------------------------------------------------------
module u8dec_back (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             q_valid_i,
  input  u8dec_pkg::item_t                 q_item_i,
  output logic                             q_pop_o,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [u8dec_pkg::CpW-1:0]        char_code_o,
  output logic                             error_seen_o,
  output logic [u8dec_pkg::LineW-1:0]      line_number_o,
  output logic                             is_end_o
);
  import u8dec_pkg::*;

  localparam logic [1:0] ModeIdle    = 2'd0;
  localparam logic [1:0] ModeCollect = 2'd1;
  localparam logic [1:0] ModeSkip    = 2'd2;

  logic [1:0]       mode_q, mode_d;
  logic [1:0]       rem_q, rem_d;
  logic [CpW-1:0]   part_q, part_d;
  logic [LineW-1:0] line_q, line_d;
  logic             err_q, err_d;

  logic             out_valid_q, out_valid_d;
  logic [CpW-1:0]   out_cp_q, out_cp_d;
  logic             out_end_q, out_end_d;

  logic             pop;
  logic             emit;
  logic [CpW-1:0]   emit_cp;
  logic             emit_end;
  logic [CpW-1:0]   part_next;
  logic [1:0]       rem_next;

  assign pop     = q_valid_i & (~out_valid_q | ~out_stall_i);
  assign q_pop_o = pop;

  assign part_next = {part_q[CpW-7:0], q_item_i.data[5:0]};
  assign rem_next  = rem_q - 2'd1;

  always_comb begin
    mode_d   = mode_q;
    rem_d    = rem_q;
    part_d   = part_q;
    line_d   = line_q;
    err_d    = err_q;
    emit     = 1'b0;
    emit_cp  = CpCleanEnd;
    emit_end = 1'b0;
    if (pop) begin
      if (q_item_i.is_end) begin
        emit     = 1'b1;
        emit_end = 1'b1;
        if (mode_q == ModeCollect) begin
          err_d   = 1'b1;
          emit_cp = CpOpenEnd;
        end else if (mode_q == ModeSkip) begin
          emit_cp = CpOpenEnd;
        end
        mode_d = ModeIdle;
        rem_d  = '0;
        part_d = '0;
      end else if (mode_q == ModeCollect) begin
        if (q_item_i.is_cont) begin
          part_d = part_next;
          rem_d  = rem_next;
          if (rem_next == 2'd0) begin
            mode_d  = ModeIdle;
            emit    = 1'b1;
            emit_cp = part_next;
          end
        end else begin
          err_d  = 1'b1;
          mode_d = ModeSkip;
          rem_d  = '0;
          part_d = '0;
        end
      end else if (mode_q == ModeSkip) begin
        if (q_item_i.is_newline) begin
          line_d  = line_q + 1'b1;
          mode_d  = ModeIdle;
          emit    = 1'b1;
          emit_cp = CpNewline;
        end
      end else begin
        if (q_item_i.is_ascii) begin
          mode_d  = ModeIdle;
          emit    = 1'b1;
          emit_cp = {{(CpW-8){1'b0}}, q_item_i.data};
          if (q_item_i.is_newline) begin
            line_d = line_q + 1'b1;
          end
        end else if (q_item_i.bad_lead) begin
          err_d  = 1'b1;
          mode_d = ModeSkip;
          rem_d  = '0;
          part_d = '0;
        end else begin
          part_d = {{(CpW-7){1'b0}}, q_item_i.lead_val};
          rem_d  = q_item_i.lead_rem;
          mode_d = ModeCollect;
        end
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_cp_d    = out_cp_q;
    out_end_d   = out_end_q;
    if (pop) begin
      out_valid_d = emit;
      out_cp_d    = emit_cp;
      out_end_d   = emit_end;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= ModeIdle;
      rem_q       <= '0;
      part_q      <= '0;
      line_q      <= '0;
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      mode_q      <= mode_d;
      rem_q       <= rem_d;
      part_q      <= part_d;
      line_q      <= line_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
    end
  end

  // error and line count are snapshotted along with the code point
  logic             out_err_q;
  logic [LineW-1:0] out_line_q;

  always_ff @(posedge clk_i) begin
    if (pop) begin
      out_cp_q   <= out_cp_d;
      out_end_q  <= out_end_d;
      out_err_q  <= err_d;
      out_line_q <= line_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign char_code_o   = out_cp_q;
  assign error_seen_o  = out_err_q;
  assign line_number_o = out_line_q;
  assign is_end_o      = out_end_q;

  a_collect_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == ModeCollect) |-> (rem_q != 2'd0))
    else $error("collecting with no bytes left");

  a_err_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    err_q |=> err_q)
    else $error("error flag cleared");

  a_line_on_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pop |=> $stable(line_q))
    else $error("line count moved without a request");

  a_end_cp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_end_q) |-> (out_cp_q == CpOpenEnd || out_cp_q == CpCleanEnd))
    else $error("bad code point on end result");

endmodule

>>> hw/rtl/utf8_byte_stream_decoder_top.sv
// ----------------------------------------------------------------------------
// utf8_byte_stream_decoder_top
// utf-8 byte stream decoder with line counting and error recovery
// ----------------------------------------------------------------------------
// one byte is accepted per clock while the queue is not full, and results
// leave at one per clock at most while out_stall_i is low; each result passes
// through the queue and the decode engine's output register. a four-entry queue
// between classifier and decode engine keeps input flowing while the output
// side stalls, so in_stall_o rises only once four requests are waiting.
module utf8_byte_stream_decoder_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [7:0]                   data_byte_i,
  input  logic                         end_of_input_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [u8dec_pkg::CpW-1:0]    char_code_o,
  output logic                         error_seen_o,
  output logic [u8dec_pkg::LineW-1:0]  line_number_o,
  output logic                         is_end_o
);
  import u8dec_pkg::*;

  logic  push;
  logic  q_full;
  logic  q_valid;
  logic  q_pop;
  item_t front_item;
  item_t q_item;

  u8dec_front u_front (
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .data_byte_i    (data_byte_i),
    .end_of_input_i (end_of_input_i),
    .q_full_i       (q_full),
    .push_o         (push),
    .item_o         (front_item)
  );

  u8dec_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .full_o  (q_full),
    .valid_o (q_valid),
    .item_o  (q_item),
    .pop_i   (q_pop)
  );

  u8dec_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_item_i      (q_item),
    .q_pop_o       (q_pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .char_code_o   (char_code_o),
    .error_seen_o  (error_seen_o),
    .line_number_o (line_number_o),
    .is_end_o      (is_end_o)
  );

endmodule
